// ===== hw/rtl/tpc_pkg.sv =====
// Shared types and constants for the triangle plane clipper.
// No dependencies.
package tpc_pkg;

  localparam int NUM_FIELDS = 9;

  localparam logic [1:0] REG_NX  = 2'd0;
  localparam logic [1:0] REG_NY  = 2'd1;
  localparam logic [1:0] REG_NZ  = 2'd2;
  localparam logic [1:0] REG_OFS = 2'd3;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIST,
    ST_CLASS,
    ST_DIV,
    ST_LERP,
    ST_EMIT
  } state_t;

  // Multiplier operand select.
  typedef enum logic [0:0] {
    MS_DIST,
    MS_LERP
  } msel_t;

endpackage

// ===== hw/rtl/tpc_mul.sv =====
// Shared signed multiplier with fractional shift and saturation, one registered stage.
// Depends on tpc_pkg.
module tpc_mul import tpc_pkg::*; #(
  parameter int W    = 32,
  parameter int FRAC = 16
) (
  input  logic                clk,
  input  logic signed [W:0]   a,
  input  logic signed [W:0]   b,
  output logic signed [63:0]  p
);
  localparam int PW = 2 * W + 2;
  logic signed [PW-1:0] full;
  logic signed [PW-1:0] shf;
  logic signed [63:0]   sat;
  localparam logic signed [63:0] LIM_HI = 64'sh0FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] LIM_LO = -64'sh1000_0000_0000_0000;

  always_comb begin
    full = PW'(a) * PW'(b);
    shf  = full >>> FRAC;
    if (shf > PW'(LIM_HI))      sat = LIM_HI;
    else if (shf < PW'(LIM_LO)) sat = LIM_LO;
    else                        sat = 64'(shf);
  end

  always_ff @(posedge clk) begin
    p <= sat;
  end
endmodule

// ===== hw/rtl/tpc_div.sv =====
// Restoring fraction divider, one quotient bit per cycle.
// Depends on tpc_pkg.
module tpc_div import tpc_pkg::*; #(
  parameter int FRAC = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [63:0]       num,
  input  logic [63:0]       den,
  output logic              done,
  output logic [FRAC-1:0]   q
);
  localparam int CW = $clog2(FRAC + 1);
  logic [64:0]     rem_r, rem_nxt;
  logic [63:0]     den_r;
  logic [FRAC-1:0] q_r, q_nxt;
  logic [CW-1:0]   cnt_r;
  logic            busy_r;
  logic [65:0]     sh;

  always_comb begin
    sh = {rem_r, 1'b0};
    if (sh >= {2'b0, den_r}) begin
      rem_nxt = 65'(sh - {2'b0, den_r});
      q_nxt   = {q_r[FRAC-2:0], 1'b1};
    end else begin
      rem_nxt = sh[64:0];
      q_nxt   = {q_r[FRAC-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= '0;
      rem_r  <= {1'b0, num};
      den_r  <= den;
      q_r    <= '0;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      q_r   <= q_nxt;
      cnt_r <= cnt_r + 1'b1;
      if (cnt_r == CW'(FRAC - 1)) busy_r <= 1'b0;
    end
  end

  assign done = busy_r && (cnt_r == CW'(FRAC - 1));
  assign q    = q_nxt;
endmodule

// ===== hw/rtl/triangle_plane_clipper_core.sv =====
// Triangle plane clipper: top level, sequencer, vertex store and output register.
// Depends on tpc_pkg, tpc_mul, tpc_div.
//
// Vertices enter on the in_ channel one word at a time. The first two of a
// triangle are stored as they are taken. The third starts a clip against the
// plane set through the cfg_ port: nine multiplies give the three distances,
// then up to two 16-step divisions and eighteen multiplies make the crossings,
// all on one shared multiplier and one serial divider. The result is 0, 3 or
// 6 vertex words on the out_ channel, end_of_run marking the last.
// For the third vertex the three distances come first, then the classify
// step, then per crossing a division and its interpolation, and then the
// words, one per cycle while out_stall is low. With nothing inside, the
// input is free again once the classify step is done. in_stall is high
// while a clip is running or its words are being delivered. When out_stall
// is high the current word holds and the sequencer waits. Reset
// (synchronous, rst_n low) empties the vertex count, drops any pending
// words and loads the default plane (z = 1).
module triangle_plane_clipper_core import tpc_pkg::*; #(
  parameter int FRAC_BITS   = 16,
  parameter int COORD_WIDTH = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [1:0]                    cfg_index,
  input  logic [COORD_WIDTH-1:0]        cfg_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [COORD_WIDTH-1:0] in_pos_x,
  input  logic signed [COORD_WIDTH-1:0] in_pos_y,
  input  logic signed [COORD_WIDTH-1:0] in_pos_z,
  input  logic signed [COORD_WIDTH-1:0] in_pos_w,
  input  logic signed [COORD_WIDTH-1:0] in_norm_x,
  input  logic signed [COORD_WIDTH-1:0] in_norm_y,
  input  logic signed [COORD_WIDTH-1:0] in_norm_z,
  input  logic signed [COORD_WIDTH-1:0] in_tex_u,
  input  logic signed [COORD_WIDTH-1:0] in_tex_v,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [COORD_WIDTH-1:0] out_pos_x,
  output logic signed [COORD_WIDTH-1:0] out_pos_y,
  output logic signed [COORD_WIDTH-1:0] out_pos_z,
  output logic signed [COORD_WIDTH-1:0] out_pos_w,
  output logic signed [COORD_WIDTH-1:0] out_norm_x,
  output logic signed [COORD_WIDTH-1:0] out_norm_y,
  output logic signed [COORD_WIDTH-1:0] out_norm_z,
  output logic signed [COORD_WIDTH-1:0] out_tex_u,
  output logic signed [COORD_WIDTH-1:0] out_tex_v,
  output logic                          out_end_of_run
);
  localparam int W = COORD_WIDTH;
  typedef logic signed [W-1:0] crd_t;
  typedef crd_t vtx_t [NUM_FIELDS];

  crd_t nx_r, ny_r, nz_r, ofs_r;
  state_t st_r, st_nxt;

  vtx_t v_r [3];   // three triangle vertices
  vtx_t x_r [2];   // crossings: x_r[0] = bc or first, x_r[1] = ac or second
  logic [1:0] cnt_r;
  logic signed [63:0] s_r [3];
  logic [2:0] ins_r;
  logic [3:0] step_r;     // multiply step
  logic [3:0] pidx_r;     // field in flight
  logic       pval_r;
  logic [1:0] cx_r;       // crossing index 0/1
  logic [2:0] emit_r, nemit_r;
  logic [FRAC_BITS-1:0] t_r;
  logic [1:0] ci_r, co_r; // inside and outside vertex of current crossing

  // emit list entry: source 0..2 vertex, 3..4 crossing
  logic [2:0] elist_r [6];

  logic acc_in;
  assign acc_in = in_valid && !in_stall;
  assign in_stall = (st_r != ST_IDLE);

  // distance step to vertex and component
  function automatic logic [1:0] step_vtx(logic [3:0] s);
    priority if (s < 4'd3) return 2'd0;
    else if (s < 4'd6)     return 2'd1;
    else                   return 2'd2;
  endfunction

  function automatic logic [1:0] step_cmp(logic [3:0] s);
    logic [3:0] r;
    priority if (s < 4'd3) r = s;
    else if (s < 4'd6)     r = s - 4'd3;
    else                   r = s - 4'd6;
    return r[1:0];
  endfunction

  // config
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nx_r <= '0; ny_r <= '0; ofs_r <= '0;
      nz_r <= crd_t'(65536);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_NX:  nx_r  <= cfg_data;
        REG_NY:  ny_r  <= cfg_data;
        REG_NZ:  nz_r  <= cfg_data;
        REG_OFS: ofs_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // shared multiplier
  logic signed [W:0] ma, mb;
  logic signed [63:0] mp;
  logic [1:0] dv, dc;
  crd_t fi;
  always_comb begin
    dv = step_vtx(step_r);
    dc = step_cmp(step_r);
    fi = v_r[ci_r][pidx_r];
    if (st_r == ST_DIST) begin
      unique case (dc)
        2'd0:    ma = (W+1)'(nx_r);
        2'd1:    ma = (W+1)'(ny_r);
        default: ma = (W+1)'(nz_r);
      endcase
      mb = (W+1)'(v_r[dv][dc]);
    end else begin
      ma = (W+1)'({1'b0, t_r});
      mb = (W+1)'(v_r[co_r][step_r]) - (W+1)'(v_r[ci_r][step_r]);
    end
  end

  tpc_mul #(.W(W), .FRAC(FRAC_BITS)) u_mul (.clk(clk), .a(ma), .b(mb), .p(mp));

  // classification helpers
  logic [1:0] nin;
  logic [1:0] k_in, c_out, a_v, b_v;
  always_comb begin
    nin   = 2'(ins_r[0]) + 2'(ins_r[1]) + 2'(ins_r[2]);
    k_in  = ins_r[0] ? 2'd0 : (ins_r[1] ? 2'd1 : 2'd2);
    c_out = !ins_r[0] ? 2'd0 : (!ins_r[1] ? 2'd1 : 2'd2);
    a_v   = (c_out == 2'd2) ? 2'd0 : c_out + 2'd1;
    b_v   = (c_out == 2'd0) ? 2'd2 : c_out - 2'd1;
  end

  // endpoints of the crossing about to start: first from classify, second after
  logic first_x;
  assign first_x = (st_r == ST_CLASS);
  logic [1:0] xi, xo;
  always_comb begin
    if (nin == 2'd1) begin
      xi = k_in;
      if (first_x) xo = (k_in == 2'd0) ? 2'd1 : 2'd0;
      else         xo = (k_in == 2'd2) ? 2'd1 : 2'd2;
    end else begin
      xo = c_out;
      xi = first_x ? b_v : a_v;
    end
  end

  // divider
  logic div_start, div_done;
  logic [FRAC_BITS-1:0] div_q;
  logic signed [63:0] si, so;
  assign si = s_r[xi];
  assign so = s_r[xo];
  tpc_div #(.FRAC(FRAC_BITS)) u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start),
    .num(si), .den(64'(si - so)), .done(div_done), .q(div_q)
  );

  logic last_x;
  assign last_x = (cx_r == 2'd1);
  logic out_free;
  assign out_free = !out_valid || !out_stall;

  // next state
  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      ST_IDLE:  if (acc_in && cnt_r == 2'd2) st_nxt = ST_DIST;
      ST_DIST:  if (!pval_r && step_r == 4'd9) st_nxt = ST_CLASS;
      ST_CLASS: begin
        if (nin == 2'd0)      st_nxt = ST_IDLE;
        else if (nin == 2'd3) st_nxt = ST_EMIT;
        else                  st_nxt = ST_DIV;
      end
      ST_DIV:   if (div_done) st_nxt = ST_LERP;
      ST_LERP:  if (!pval_r && step_r == 4'd9)
                  st_nxt = last_x ? ST_EMIT : ST_DIV;
      ST_EMIT:  if (out_free && emit_r == nemit_r) st_nxt = ST_IDLE;
      default:  st_nxt = ST_IDLE;
    endcase
  end

  assign div_start = (st_r == ST_CLASS && (nin == 2'd1 || nin == 2'd2)) ||
                     (st_r == ST_LERP && !pval_r && step_r == 4'd9 && !last_x);

  // output word
  vtx_t ow;
  always_comb begin
    logic [2:0] src;
    src = elist_r[emit_r];
    if (src < 3'd3) ow = v_r[src[1:0]];
    else            ow = x_r[(src == 3'd3) ? 0 : 1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
      cnt_r <= '0;
      out_valid <= 1'b0;
      pval_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (out_valid && !out_stall && st_r != ST_EMIT) out_valid <= 1'b0;
      if (acc_in) begin
        v_r[cnt_r] <= '{in_pos_x, in_pos_y, in_pos_z, in_pos_w, in_norm_x,
                        in_norm_y, in_norm_z, in_tex_u, in_tex_v};
        cnt_r <= (cnt_r == 2'd2) ? 2'd0 : cnt_r + 2'd1;
        step_r <= '0;
        pval_r <= 1'b0;
        s_r[0] <= 64'(ofs_r); s_r[1] <= 64'(ofs_r); s_r[2] <= 64'(ofs_r);
      end
      unique case (st_r)
        ST_DIST: begin
          pval_r <= (step_r != 4'd9);
          pidx_r <= step_r;
          if (step_r != 4'd9) step_r <= step_r + 4'd1;
          if (pval_r) s_r[step_vtx(pidx_r)] <= s_r[step_vtx(pidx_r)] + mp;
          if (!pval_r && step_r == 4'd9) begin
            ins_r <= {~s_r[2][63], ~s_r[1][63], ~s_r[0][63]};
          end
        end
        ST_CLASS: begin
          cx_r <= '0;
          ci_r <= xi; co_r <= xo;
          emit_r <= '0;
          if (nin == 2'd3) begin
            nemit_r <= 3'd2;
            elist_r <= '{3'd0, 3'd1, 3'd2, 3'd0, 3'd0, 3'd0};
          end else if (nin == 2'd1) begin
            nemit_r <= 3'd2;
            if (k_in == 2'd0) elist_r <= '{3'd0, 3'd3, 3'd4, 3'd0, 3'd0, 3'd0};
            else if (k_in == 2'd1) elist_r <= '{3'd3, 3'd1, 3'd4, 3'd0, 3'd0, 3'd0};
            else elist_r <= '{3'd3, 3'd4, 3'd2, 3'd0, 3'd0, 3'd0};
          end else begin
            nemit_r <= 3'd5;
            elist_r <= '{{1'b0, b_v}, 3'd3, {1'b0, a_v}, 3'd3, 3'd4, {1'b0, a_v}};
          end
        end
        ST_DIV: begin
          if (div_done) begin
            t_r <= div_q;
            step_r <= '0;
            pval_r <= 1'b0;
          end
        end
        ST_LERP: begin
          pval_r <= (step_r != 4'd9);
          pidx_r <= step_r;
          if (step_r != 4'd9) step_r <= step_r + 4'd1;
          if (pval_r) x_r[cx_r[0]][pidx_r] <= W'(64'(fi) + mp);
          if (!pval_r && step_r == 4'd9) begin
            cx_r <= 2'd1;
            ci_r <= xi;
            co_r <= xo;
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            out_valid <= 1'b1;
            {out_pos_x, out_pos_y, out_pos_z, out_pos_w, out_norm_x, out_norm_y,
             out_norm_z, out_tex_u, out_tex_v} <= {ow[0], ow[1], ow[2], ow[3],
             ow[4], ow[5], ow[6], ow[7], ow[8]};
            out_end_of_run <= (emit_r == nemit_r);
            emit_r <= emit_r + 3'd1;
          end
        end
        default: ;
      endcase
    end
  end
endmodule

// ===== verif/testbench.sv =====
// Self-checking testbench for triangle_plane_clipper_core: directed and random triangles
// against a built-in plane clipping predictor. Depends on tpc_pkg and the core RTL.
module testbench;
  import tpc_pkg::*;

  localparam int FB = 16;
  localparam int CW = 32;
  localparam int WATCHDOG = 20000;
  localparam longint SAT = 64'sd1 <<< 60;

  typedef logic signed [CW-1:0] fld_t;
  typedef fld_t vtx_t [NUM_FIELDS];
  typedef struct {
    vtx_t v;
    logic eor;
  } word_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = REG_NX;
  logic [CW-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  fld_t in_f [NUM_FIELDS];
  logic out_valid;
  logic out_stall = 1'b1;
  fld_t out_f [NUM_FIELDS];
  logic out_end_of_run;

  string fname [NUM_FIELDS] = '{"out_pos_x", "out_pos_y", "out_pos_z", "out_pos_w",
                                "out_norm_x", "out_norm_y", "out_norm_z",
                                "out_tex_u", "out_tex_v"};

  longint plane_n [3];
  longint plane_ofs;
  vtx_t held [2];
  int held_cnt;
  word_t clip_q [$];
  int errors = 0;
  int quiet = 0;
  int hold_off = 0;
  int idle_pct = 31;

  initial for (int i = 0; i < NUM_FIELDS; i++) in_f[i] = '0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  triangle_plane_clipper_core dut (
    .clk, .rst_n, .cfg_we, .cfg_index, .cfg_data, .in_valid, .in_stall,
    .in_pos_x(in_f[0]), .in_pos_y(in_f[1]), .in_pos_z(in_f[2]), .in_pos_w(in_f[3]),
    .in_norm_x(in_f[4]), .in_norm_y(in_f[5]), .in_norm_z(in_f[6]),
    .in_tex_u(in_f[7]), .in_tex_v(in_f[8]),
    .out_valid, .out_stall,
    .out_pos_x(out_f[0]), .out_pos_y(out_f[1]), .out_pos_z(out_f[2]),
    .out_pos_w(out_f[3]), .out_norm_x(out_f[4]), .out_norm_y(out_f[5]),
    .out_norm_z(out_f[6]), .out_tex_u(out_f[7]), .out_tex_v(out_f[8]),
    .out_end_of_run
  );

  // floor(a*b / 2^FB) with saturation, exact through 128-bit product
  function automatic longint fix_mul(longint a, longint b);
    logic signed [127:0] p;
    p = (128'(signed'(a)) * 128'(signed'(b))) >>> FB;
    if (p > 128'(SAT - 1)) return SAT - 1;
    if (p < -128'(SAT)) return -SAT;
    return longint'(p);
  endfunction

  function automatic longint plane_dist(vtx_t v);
    return fix_mul(plane_n[0], v[0]) + fix_mul(plane_n[1], v[1]) +
           fix_mul(plane_n[2], v[2]) + plane_ofs;
  endfunction

  function automatic vtx_t cross_vtx(vtx_t vi, longint si, vtx_t vo, longint so);
    vtx_t r;
    longint t;
    logic signed [127:0] num;
    num = 128'(si) <<< FB;
    t = longint'(num / 128'(si - so));
    for (int f = 0; f < NUM_FIELDS; f++)
      r[f] = fld_t'(longint'(vi[f]) + fix_mul(t, longint'(vo[f]) - longint'(vi[f])));
    return r;
  endfunction

  function automatic void push_word(vtx_t v, logic eor);
    word_t w;
    w.v = v;
    w.eor = eor;
    clip_q.push_back(w);
  endfunction

  function automatic void predict_clip(vtx_t vin);
    vtx_t v [3];
    longint s [3];
    int ins [3];
    int cnt, k, c, a, b;
    vtx_t bc, ac;
    if (held_cnt < 2) begin
      held[held_cnt] = vin;
      held_cnt++;
      return;
    end
    held_cnt = 0;
    v[0] = held[0];
    v[1] = held[1];
    v[2] = vin;
    cnt = 0;
    for (int n = 0; n < 3; n++) begin
      s[n] = plane_dist(v[n]);
      ins[n] = s[n] >= 0;
      cnt += ins[n];
    end
    if (cnt == 0) return;
    if (cnt == 2) begin
      c = !ins[0] ? 0 : (!ins[1] ? 1 : 2);
      a = (c + 1) % 3;
      b = (c + 2) % 3;
      bc = cross_vtx(v[b], s[b], v[c], s[c]);
      ac = cross_vtx(v[a], s[a], v[c], s[c]);
      push_word(v[b], 0); push_word(bc, 0); push_word(v[a], 0);
      push_word(bc, 0); push_word(ac, 0); push_word(v[a], 1);
      return;
    end
    if (cnt == 1) begin
      k = ins[0] ? 0 : (ins[1] ? 1 : 2);
      for (int n = 0; n < 3; n++)
        if (n != k) v[n] = cross_vtx(v[k], s[k], v[n], s[n]);
    end
    for (int n = 0; n < 3; n++) push_word(v[n], n == 2);
  endfunction

  task automatic send_vertex(vtx_t v);
    while (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    for (int f = 0; f < NUM_FIELDS; f++) in_f[f] <= v[f];
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_clip(v);
  endtask

  task automatic write_plane(logic [1:0] idx, longint val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val[CW-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_OFS) plane_ofs = longint'(fld_t'(val));
    else plane_n[idx] = longint'(fld_t'(val));
    @(posedge clk);
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    while (clip_q.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  function automatic fld_t rnd_fld(int mode);
    case (mode)
      0: return fld_t'($urandom);
      1: return fld_t'($urandom_range(0, 'h40000)) - fld_t'('h20000);
      default: return fld_t'($urandom_range(0, 'h1000000)) - fld_t'('h800000);
    endcase
  endfunction

  function automatic vtx_t rnd_vtx(int mode);
    vtx_t v;
    for (int f = 0; f < NUM_FIELDS; f++) v[f] = rnd_fld(mode);
    return v;
  endfunction

  function automatic vtx_t at_z(int z);
    vtx_t v;
    v = rnd_vtx(1);
    v[2] = fld_t'(z);
    return v;
  endfunction

  task automatic test_cases_z_plane;
    vtx_t v;
    // all in, all out, one in, two in (each outside position), boundary zero
    send_vertex(at_z(1)); send_vertex(at_z(2)); send_vertex(at_z(0));
    send_vertex(at_z(-1)); send_vertex(at_z(-5)); send_vertex(at_z(-9));
    send_vertex(at_z('h10000)); send_vertex(at_z(-'h10000)); send_vertex(at_z(-'h30000));
    send_vertex(at_z(-'h10000)); send_vertex(at_z('h20000)); send_vertex(at_z('h10000));
    send_vertex(at_z('h8000)); send_vertex(at_z('h8000)); send_vertex(at_z(-'h8000));
    for (int f = 0; f < NUM_FIELDS; f++) v[f] = fld_t'(32'h7fffffff);
    send_vertex(v);
    for (int f = 0; f < NUM_FIELDS; f++) v[f] = fld_t'(32'h80000000);
    send_vertex(v);
    v[2] = '0;
    send_vertex(v);
    drain();
  endtask

  task automatic test_plane_settings;
    write_plane(REG_NX, 'h10000);
    write_plane(REG_NY, -'h8000);
    write_plane(REG_NZ, 'h7fffffff);
    write_plane(REG_OFS, -'h80000000);
    for (int i = 0; i < 12; i++) send_vertex(rnd_vtx(0));
    drain();
    write_plane(REG_NX, -'h80000000);
    write_plane(REG_NY, 'h7fffffff);
    write_plane(REG_NZ, -'h80000000);
    write_plane(REG_OFS, 'h7fffffff);
    for (int i = 0; i < 12; i++) send_vertex(rnd_vtx(0));
    drain();
  endtask

  task automatic test_random(int n_items);
    for (int i = 0; i < n_items; i++) begin
      if (i % 45 == 0) begin
        drain();
        write_plane(REG_NX, longint'(rnd_fld(1)));
        write_plane(REG_NY, longint'(rnd_fld(1)));
        write_plane(REG_NZ, longint'(rnd_fld(1)));
        write_plane(REG_OFS, longint'(rnd_fld(2)));
      end
      if (i >= 90 && i < 120) idle_pct = 0;
      else idle_pct = 31;
      send_vertex(rnd_vtx($urandom_range(9) == 0 ? 0 : $urandom_range(1, 2)));
    end
    idle_pct = 31;
  endtask

  task automatic test_backpressure;
    hold_off = 300;
    for (int i = 0; i < 15; i++) send_vertex(at_z($urandom_range(0, 4) * 'h4000 - 'h8000));
    drain();
  endtask

  always @(posedge clk) begin
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_stall <= 1'b1;
    end else
      out_stall <= idle_pct > 0 && $urandom_range(99) < idle_pct;
  end

  always @(posedge clk) begin
    word_t w;
    if (rst_n && out_valid && !out_stall) begin
      if (clip_q.size() == 0) begin
        $error("unexpected output word");
        errors++;
      end else begin
        w = clip_q.pop_front();
        for (int f = 0; f < NUM_FIELDS; f++)
          if (out_f[f] !== w.v[f]) begin
            $error("%s: expected %0d actual %0d", fname[f], w.v[f], out_f[f]);
            errors++;
          end
        if (out_end_of_run !== w.eor) begin
          $error("out_end_of_run: expected %0b actual %0b", w.eor, out_end_of_run);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= WATCHDOG) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    plane_n[0] = 0;
    plane_n[1] = 0;
    plane_n[2] = 'h10000;
    plane_ofs = 0;
    held_cnt = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_cases_z_plane();
    test_plane_settings();
    test_backpressure();
    test_random(173);
    drain();
    if (errors == 0 && clip_q.size() == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end
endmodule
